>>> hdl/dss_pkg.sv
package dss_pkg;

  // Sizing of the request store and the track datapath.
  localparam int TRACK_BITS  = 12;
  localparam int QUEUE_DEPTH = 32;
  localparam int QADDR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_BITS  = TRACK_BITS + 1;

  localparam logic [CNT_BITS-1:0]   FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [TRACK_BITS-1:0] END_TRACK_RESET = TRACK_BITS'(199);

  // Input item kinds and sweep directions.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;
  localparam logic DIR_LEFT   = 1'b0;
  localparam logic DIR_RIGHT  = 1'b1;

  // Access request from the sequencer to the request store.
  typedef struct packed {
    logic                  we;
    logic [QADDR_BITS-1:0] waddr;
    logic [TRACK_BITS-1:0] wdata;
    logic                  re;
    logic [QADDR_BITS-1:0] raddr;
  } store_req_t;

  // Result of the shared compare and subtract unit.
  typedef struct packed {
    logic                  gt;
    logic [TRACK_BITS-1:0] absd;
  } alu_res_t;

endpackage

>>> hdl/disk_scan_scheduler.sv
// Load beat: CAP_IN clamps the track, LD_CMP compares it against the stored requests from the top
// down and shifts each larger one up, and LD_PUT writes it; the walk stops at the first one not above it.
// Start beat: SC_CAP/SC_CMP search for the split and LEG opens the first leg, MV_CAP/MV_DIST serve each
// request, then follow the boundary sweep, the second leg, the summary beat and the return to idle.
// One beat is in work at a time; output stall can hold the service moves and the summary beat.
// Reset (rst_n low, synchronous) empties the store count, clears the result and sets end_track to 199.
module disk_scan_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dss_pkg::TRACK_BITS-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [dss_pkg::TRACK_BITS-1:0]   in_track,
  input  logic                             in_direction,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dss_pkg::TRACK_BITS-1:0]   out_from_track,
  output logic [dss_pkg::TRACK_BITS-1:0]   out_to_track,
  output logic [dss_pkg::TOTAL_BITS-1:0]   out_running_total,
  output logic                             out_is_summary,
  output logic                             out_last
);
  import dss_pkg::*;

  // The sequencer. Loads go CAP_IN -> LD_CMP (insertion shift) -> LD_PUT.
  // Starts go CAP_IN -> SC_CAP/SC_CMP (split search) -> LEG -> MV_CAP/MV_DIST
  // for each request of the first leg -> SWEEP -> LEG -> second leg -> SUM.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP_IN,
    ST_LD_CMP,
    ST_LD_PUT,
    ST_SC_CAP,
    ST_SC_CMP,
    ST_LEG,
    ST_MV_CAP,
    ST_MV_DIST,
    ST_SWEEP,
    ST_SUM
  } state_t;

  state_t                state_r, state_nxt;
  logic [TRACK_BITS-1:0] end_track_r, end_track_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;

  // Working registers of the beat in progress.
  logic                  kind_r, kind_nxt;
  logic                  dir_r, dir_nxt;
  logic [TRACK_BITS-1:0] trk_r, trk_nxt;
  logic [TRACK_BITS-1:0] head_r, head_nxt;
  logic [TRACK_BITS-1:0] cap_r, cap_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [CNT_BITS-1:0]   pos_r, pos_nxt;
  logic [CNT_BITS-1:0]   idx_r, idx_nxt;
  logic [CNT_BITS-1:0]   split_r, split_nxt;
  logic [CNT_BITS-1:0]   ptr_r, ptr_nxt;
  logic                  phase_r, phase_nxt;

  // Result register; it separates the sequencer from the output handshake.
  logic                  out_valid_r, out_valid_nxt;
  logic [TRACK_BITS-1:0] out_from_r, out_from_nxt;
  logic [TRACK_BITS-1:0] out_to_r, out_to_nxt;
  logic [TOTAL_BITS-1:0] out_total_r, out_total_nxt;
  logic                  out_sum_r, out_sum_nxt;
  logic                  out_last_r, out_last_nxt;

  store_req_t            st_req;
  logic [TRACK_BITS-1:0] rd_data;
  logic [TRACK_BITS-1:0] alu_a;
  logic [TRACK_BITS-1:0] alu_b;
  alu_res_t              alu_res;

  logic                  out_free;
  logic                  leg_asc;
  logic [TRACK_BITS-1:0] clamp_val;
  logic [TOTAL_BITS-1:0] total_sum;
  logic [CNT_BITS-1:0]   ptr_inc;

  dss_store u_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (rd_data)
  );

  dss_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // The result slot can take a new beat when it is empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // A leg runs upward when sweeping right first, or on the return leg after
  // a left sweep.
  assign leg_asc = dir_r ^ phase_r;

  // Clamp of the unit's first operand to the second one, used whenever
  // the unit compares a track against end_track.
  assign clamp_val = alu_res.gt ? alu_b : alu_a;

  // Running total plus the distance from the unit, saturating at all ones.
  always_comb begin
    logic [TOTAL_BITS:0] wide;
    wide = {1'b0, total_r} + {2'b00, alu_res.absd};
    total_sum = wide[TOTAL_BITS] ? '1 : wide[TOTAL_BITS-1:0];
  end

  assign ptr_inc = ptr_r + CNT_BITS'(1);

  always_comb begin
    state_nxt     = state_r;
    end_track_nxt = cfg_we ? cfg_wdata : end_track_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    trk_nxt       = trk_r;
    head_nxt      = head_r;
    cap_nxt       = cap_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    split_nxt     = split_r;
    ptr_nxt       = ptr_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_total_nxt = out_total_r;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;
    st_req        = '0;
    alu_a         = head_r;
    alu_b         = cap_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          trk_nxt   = in_track;
          dir_nxt   = in_direction;
          state_nxt = ST_CAP_IN;
        end
      end

      // Clamp the incoming track to end_track, then branch on the kind.
      ST_CAP_IN: begin
        alu_a = trk_r;
        alu_b = end_track_r;
        if (kind_r == KIND_LOAD) begin
          trk_nxt = clamp_val;
          pos_nxt = count_r;
          if (count_r == FULL_COUNT) begin
            // The store is full, so the request is dropped.
            state_nxt = ST_IDLE;
          end else if (count_r == '0) begin
            state_nxt = ST_LD_PUT;
          end else begin
            st_req.re    = 1'b1;
            st_req.raddr = QADDR_BITS'(count_r - CNT_BITS'(1));
            state_nxt    = ST_LD_CMP;
          end
        end else begin
          head_nxt  = clamp_val;
          total_nxt = '0;
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          split_nxt = '0;
          if (count_r == '0) begin
            state_nxt = ST_LEG;
          end else begin
            st_req.re    = 1'b1;
            st_req.raddr = '0;
            state_nxt    = ST_SC_CAP;
          end
        end
      end

      // Insertion: shift larger entries up by one, one entry a cycle.
      ST_LD_CMP: begin
        alu_a = rd_data;
        alu_b = trk_r;
        if (alu_res.gt) begin
          st_req.we    = 1'b1;
          st_req.waddr = QADDR_BITS'(pos_r);
          st_req.wdata = rd_data;
          pos_nxt      = pos_r - CNT_BITS'(1);
          if (pos_r == CNT_BITS'(1)) begin
            state_nxt = ST_LD_PUT;
          end else begin
            st_req.re    = 1'b1;
            st_req.raddr = QADDR_BITS'(pos_r - CNT_BITS'(2));
          end
        end else begin
          state_nxt = ST_LD_PUT;
        end
      end

      ST_LD_PUT: begin
        st_req.we    = 1'b1;
        st_req.waddr = QADDR_BITS'(pos_r);
        st_req.wdata = trk_r;
        count_nxt    = count_r + CNT_BITS'(1);
        state_nxt    = ST_IDLE;
      end

      // Split search: first stored request, clamped, at or above the head.
      ST_SC_CAP: begin
        alu_a     = rd_data;
        alu_b     = end_track_r;
        cap_nxt   = clamp_val;
        state_nxt = ST_SC_CMP;
      end

      ST_SC_CMP: begin
        alu_a = head_r;
        alu_b = cap_r;
        if (!alu_res.gt) begin
          split_nxt = idx_r;
          state_nxt = ST_LEG;
        end else if (idx_r + CNT_BITS'(1) == count_r) begin
          split_nxt = count_r;
          state_nxt = ST_LEG;
        end else begin
          idx_nxt      = idx_r + CNT_BITS'(1);
          st_req.re    = 1'b1;
          st_req.raddr = QADDR_BITS'(idx_r + CNT_BITS'(1));
          state_nxt    = ST_SC_CAP;
        end
      end

      // Start of a leg: pick the first request or finish the leg at once.
      ST_LEG: begin
        if (leg_asc && split_r < count_r) begin
          ptr_nxt      = split_r;
          st_req.re    = 1'b1;
          st_req.raddr = QADDR_BITS'(split_r);
          state_nxt    = ST_MV_CAP;
        end else if (!leg_asc && split_r != '0) begin
          ptr_nxt      = split_r - CNT_BITS'(1);
          st_req.re    = 1'b1;
          st_req.raddr = QADDR_BITS'(split_r - CNT_BITS'(1));
          state_nxt    = ST_MV_CAP;
        end else begin
          state_nxt = phase_r ? ST_SUM : ST_SWEEP;
        end
      end

      ST_MV_CAP: begin
        alu_a     = rd_data;
        alu_b     = end_track_r;
        cap_nxt   = clamp_val;
        state_nxt = ST_MV_DIST;
      end

      // One service move: wait for the result slot, then step the pointer.
      ST_MV_DIST: begin
        alu_a = head_r;
        alu_b = cap_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_from_nxt  = head_r;
          out_to_nxt    = cap_r;
          out_total_nxt = total_sum;
          out_sum_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          total_nxt     = total_sum;
          head_nxt      = cap_r;
          if (leg_asc && ptr_inc < count_r) begin
            ptr_nxt      = ptr_inc;
            st_req.re    = 1'b1;
            st_req.raddr = QADDR_BITS'(ptr_inc);
            state_nxt    = ST_MV_CAP;
          end else if (!leg_asc && ptr_r != '0) begin
            ptr_nxt      = ptr_r - CNT_BITS'(1);
            st_req.re    = 1'b1;
            st_req.raddr = QADDR_BITS'(ptr_r - CNT_BITS'(1));
            state_nxt    = ST_MV_CAP;
          end else begin
            state_nxt = phase_r ? ST_SUM : ST_SWEEP;
          end
        end
      end

      // Boundary sweep to track 0 or to end_track; it counts even when no
      // request lies beyond it.
      ST_SWEEP: begin
        alu_a     = head_r;
        alu_b     = (dir_r == DIR_RIGHT) ? end_track_r : '0;
        total_nxt = total_sum;
        head_nxt  = alu_b;
        phase_nxt = 1'b1;
        state_nxt = ST_LEG;
      end

      // Summary beat closes the run and empties the store.
      ST_SUM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_from_nxt  = '0;
          out_to_nxt    = '0;
          out_total_nxt = total_r;
          out_sum_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          count_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      end_track_r <= END_TRACK_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      end_track_r <= end_track_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    dir_r       <= dir_nxt;
    trk_r       <= trk_nxt;
    head_r      <= head_nxt;
    cap_r       <= cap_nxt;
    total_r     <= total_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    split_r     <= split_nxt;
    ptr_r       <= ptr_nxt;
    phase_r     <= phase_nxt;
    out_from_r  <= out_from_nxt;
    out_to_r    <= out_to_nxt;
    out_total_r <= out_total_nxt;
    out_sum_r   <= out_sum_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Input beats are taken only between runs.
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_from_track    = out_from_r;
  assign out_to_track      = out_to_r;
  assign out_running_total = out_total_r;
  assign out_is_summary    = out_sum_r;
  assign out_last          = out_last_r;

  // The store never holds more requests than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("request count beyond store depth");

  // Issuing the summary beat empties the store.
  a_sum_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && out_free) |=> (count_r == '0))
    else $error("store not emptied with the summary beat");

  // A summary beat carries zero tracks and closes the run.
  a_sum_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sum_r) |-> (out_from_r == '0 && out_to_r == '0 && out_last_r))
    else $error("malformed summary beat");

  // The walk pointer stays inside the filled part, the insertion point at most one past it.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MV_CAP || state_r == ST_MV_DIST) |-> (ptr_r < count_r))
    else $error("walk pointer outside the stored requests");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LD_CMP || state_r == ST_LD_PUT) |-> (pos_r <= count_r))
    else $error("insertion point beyond the stored requests");

endmodule

>>> hdl/dss_store.sv
module dss_store (
  input  logic                            clk,
  input  dss_pkg::store_req_t             req,
  output logic [dss_pkg::TRACK_BITS-1:0]  rdata
);
  import dss_pkg::*;

  logic [TRACK_BITS-1:0] mem [QUEUE_DEPTH];
  logic [TRACK_BITS-1:0] rdata_r;

  // One write port and one read port; the read data is registered and
  // holds its value while no read is requested.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/dss_alu.sv
module dss_alu (
  input  logic [dss_pkg::TRACK_BITS-1:0] a,
  input  logic [dss_pkg::TRACK_BITS-1:0] b,
  output dss_pkg::alu_res_t              res
);
  import dss_pkg::*;

  logic [TRACK_BITS:0]   diff;
  logic [TRACK_BITS-1:0] low;
  logic                  borrow;

  // One subtractor gives both the ordering and the distance.
  assign diff   = {1'b0, a} - {1'b0, b};
  assign low    = diff[TRACK_BITS-1:0];
  assign borrow = diff[TRACK_BITS];

  assign res.gt   = !borrow && (low != '0);
  assign res.absd = borrow ? (~low + TRACK_BITS'(1)) : low;

endmodule
